@@ hw/rtl/fcsr_pkg.sv @@
// ----------------------------------------------------------------------------
// fcsr_pkg
// Shared constants and types for the framed command sample reporter.
// ----------------------------------------------------------------------------
package fcsr_pkg;

    localparam int RING_DEPTH_DEF = 8;
    localparam int FRAME_DEPTH    = 8;
    localparam int POS_W          = 4;

    // framing and command bytes
    localparam logic [7:0] FRAME_OPEN  = 8'h01;
    localparam logic [7:0] FRAME_CLOSE = 8'h04;
    localparam logic [7:0] BYTE_INSTR  = 8'hFF;
    localparam logic [7:0] BYTE_DUMP   = 8'hF0;
    localparam logic [7:0] BYTE_NEWEST = 8'hF1;

    // reply characters
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_COMMA = 8'h2C;
    localparam logic [7:0] ASCII_E     = 8'h45;
    localparam logic [7:0] ASCII_R     = 8'h52;
    localparam logic [7:0] ASCII_O     = 8'h4F;

    // byte slots within one four-byte reply group
    localparam logic [1:0] SLOT_HUND  = 2'd0;
    localparam logic [1:0] SLOT_TENS  = 2'd1;
    localparam logic [1:0] SLOT_UNITS = 2'd2;
    localparam logic [1:0] SLOT_LAST  = 2'd3;

    typedef struct packed {
        logic [4:0] quot;
        logic [3:0] rem;
    } div_res_t;

endpackage

@@ hw/rtl/fcsr_div10.sv @@
// ----------------------------------------------------------------------------
// fcsr_div10
// Divide-by-ten step shared by the sequencer: quotient and remainder of an
// 8-bit value, by reciprocal multiply and correction-free back subtraction.
// ----------------------------------------------------------------------------
module fcsr_div10
    import fcsr_pkg::*;
(
    input  logic [7:0] dividend,
    output div_res_t   res
);

    logic [15:0] product;
    logic [4:0]  quot;
    logic [7:0]  quot_x10;
    logic [7:0]  diff;

    // x * 205 >> 11 is exact for every 8-bit x
    assign product  = 16'(dividend) * 16'd205;
    assign quot     = product[15:11];
    assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign diff     = dividend - quot_x10;

    assign res.quot = quot;
    assign res.rem  = diff[3:0];

endmodule

@@ hw/rtl/framed_command_sample_reporter_unit.sv @@
// ----------------------------------------------------------------------------
// framed_command_sample_reporter_unit
// Sample ring plus framed serial command decoder; dumps or reports samples
// as ASCII decimal text, one reply byte per transfer.
// ----------------------------------------------------------------------------
//  channel | ports                                  | direction
//  s_      | s_valid s_ready s_req_type s_rx_byte   | in, one item per transfer
//          | s_sample                               |
//  m_      | m_valid m_ready m_tx_byte m_last       | out, one reply byte each
//
//  a dump scans every ring slot from the oldest and emits a four-byte group
//  per valid sample; newest replies with one group, or ERRO; the shared
//  divide-by-ten step runs twice per sample and the output register gives
//  one byte per cycle while m_ready allows
//  s_ready is low while a reply is being built; m_ready low stalls it
//  aresetn clears frame state, ring valid marks and the write pointer
// ----------------------------------------------------------------------------
module framed_command_sample_reporter_unit
    import fcsr_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_rx_byte,
    input  logic [7:0] s_sample,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_tx_byte,
    output logic       m_last
);

    localparam int RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int SW = RW + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_EMIT,
        ST_ERR
    } state_t;

    function automatic logic [RW-1:0] wrap_add(input logic [RW-1:0] base,
                                               input logic [CW-1:0] ofs);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(ofs);
        if (s >= SW'(RING_DEPTH)) begin
            s = s - SW'(RING_DEPTH);
        end
        return s[RW-1:0];
    endfunction

    // ring storage
    logic [7:0]            ring_value_reg [RING_DEPTH];
    logic [RING_DEPTH-1:0] ring_valid_reg;
    logic [RW-1:0]         wptr_reg;

    // sequencer and frame state
    state_t          state_reg, state_next;
    logic            active_reg, active_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]      byte_one_reg, byte_one_next;
    logic [7:0]      byte_two_reg, byte_two_next;
    logic            newest_reg, newest_next;
    logic [CW-1:0]   scan_cnt_reg, scan_cnt_next;
    logic            last_sample_reg, last_sample_next;
    logic [4:0]      quot_reg, quot_next;
    logic [3:0]      units_reg, units_next;
    logic [3:0]      tens_reg, tens_next;
    logic [1:0]      hund_reg, hund_next;
    logic [1:0]      byte_cnt_reg, byte_cnt_next;
    logic            m_valid_reg, m_valid_next;
    logic [7:0]      m_tx_byte_reg, m_tx_byte_next;
    logic            m_last_reg, m_last_next;

    logic          accept;
    logic          out_free;
    logic          ring_write;
    logic [RW-1:0] newest_idx;
    logic [RW-1:0] rd_idx;
    logic [7:0]    rd_value;
    logic          rd_valid;
    logic          more_valid;
    logic [7:0]    div_in;
    div_res_t      div_res;

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign ring_write = accept && s_req_type;

    assign newest_idx = (wptr_reg == '0) ? RW'(RING_DEPTH - 1) : wptr_reg - 1'b1;
    assign rd_idx     = newest_reg ? newest_idx : wrap_add(wptr_reg, scan_cnt_reg);
    assign rd_value   = ring_value_reg[rd_idx];
    assign rd_valid   = ring_valid_reg[rd_idx];

    // any valid entry later in scan order decides the last flag of a dump
    always_comb begin
        more_valid = 1'b0;
        for (int k = 0; k < RING_DEPTH; k++) begin
            if ((CW'(k) > scan_cnt_reg) && ring_valid_reg[wrap_add(wptr_reg, CW'(k))]) begin
                more_valid = 1'b1;
            end
        end
    end

    assign div_in = (state_reg == ST_SCAN) ? rd_value : {3'b000, quot_reg};

    fcsr_div10 u_div10 (
        .dividend (div_in),
        .res      (div_res)
    );

    always_comb begin
        state_next       = state_reg;
        active_next      = active_reg;
        pos_next         = pos_reg;
        byte_one_next    = byte_one_reg;
        byte_two_next    = byte_two_reg;
        newest_next      = newest_reg;
        scan_cnt_next    = scan_cnt_reg;
        last_sample_next = last_sample_reg;
        quot_next        = quot_reg;
        units_next       = units_reg;
        tens_next        = tens_reg;
        hund_next        = hund_reg;
        byte_cnt_next    = byte_cnt_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_tx_byte_next   = m_tx_byte_reg;
        m_last_next      = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept && !s_req_type) begin
                    if (!active_reg) begin
                        if (s_rx_byte == FRAME_OPEN) begin
                            active_next = 1'b1;
                            pos_next    = POS_W'(1);
                        end
                    end else if (s_rx_byte == FRAME_CLOSE ||
                                 pos_reg >= POS_W'(FRAME_DEPTH - 1)) begin
                        active_next   = 1'b0;
                        pos_next      = '0;
                        scan_cnt_next = '0;
                        if (pos_reg >= POS_W'(3) && byte_one_reg == BYTE_INSTR) begin
                            if (byte_two_reg == BYTE_DUMP && pos_reg == POS_W'(3)) begin
                                newest_next = 1'b0;
                                state_next  = ST_SCAN;
                            end else if (byte_two_reg == BYTE_NEWEST) begin
                                newest_next = 1'b1;
                                state_next  = ST_SCAN;
                            end
                        end
                    end else begin
                        if (pos_reg == POS_W'(1)) begin
                            byte_one_next = s_rx_byte;
                        end else if (pos_reg == POS_W'(2)) begin
                            byte_two_next = s_rx_byte;
                        end
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (newest_reg) begin
                    if (rd_valid) begin
                        quot_next        = div_res.quot;
                        units_next       = div_res.rem;
                        last_sample_next = 1'b1;
                        state_next       = ST_DIV;
                    end else begin
                        byte_cnt_next = SLOT_HUND;
                        state_next    = ST_ERR;
                    end
                end else if (scan_cnt_reg == CW'(RING_DEPTH)) begin
                    state_next = ST_IDLE;
                end else if (rd_valid) begin
                    quot_next        = div_res.quot;
                    units_next       = div_res.rem;
                    last_sample_next = !more_valid;
                    state_next       = ST_DIV;
                end else begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            ST_DIV: begin
                hund_next     = div_res.quot[1:0];
                tens_next     = div_res.rem;
                byte_cnt_next = SLOT_HUND;
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_last_next   = (byte_cnt_reg == SLOT_LAST) && last_sample_reg;
                    byte_cnt_next = byte_cnt_reg + 1'b1;
                    case (byte_cnt_reg)
                        SLOT_HUND:  m_tx_byte_next = ASCII_ZERO + {6'b000000, hund_reg};
                        SLOT_TENS:  m_tx_byte_next = ASCII_ZERO + {4'b0000, tens_reg};
                        SLOT_UNITS: m_tx_byte_next = ASCII_ZERO + {4'b0000, units_reg};
                        default:    m_tx_byte_next = ASCII_COMMA;
                    endcase
                    if (byte_cnt_reg == SLOT_LAST) begin
                        if (newest_reg) begin
                            state_next = ST_IDLE;
                        end else begin
                            scan_cnt_next = scan_cnt_reg + 1'b1;
                            state_next    = ST_SCAN;
                        end
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_last_next   = (byte_cnt_reg == SLOT_LAST);
                    byte_cnt_next = byte_cnt_reg + 1'b1;
                    case (byte_cnt_reg)
                        SLOT_HUND: m_tx_byte_next = ASCII_E;
                        SLOT_LAST: m_tx_byte_next = ASCII_O;
                        default:   m_tx_byte_next = ASCII_R;
                    endcase
                    if (byte_cnt_reg == SLOT_LAST) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            active_reg   <= 1'b0;
            pos_reg      <= '0;
            byte_one_reg <= '0;
            byte_two_reg <= '0;
            newest_reg   <= 1'b0;
            scan_cnt_reg <= '0;
            byte_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            active_reg   <= active_next;
            pos_reg      <= pos_next;
            byte_one_reg <= byte_one_next;
            byte_two_reg <= byte_two_next;
            newest_reg   <= newest_next;
            scan_cnt_reg <= scan_cnt_next;
            byte_cnt_reg <= byte_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
        last_sample_reg <= last_sample_next;
        quot_reg        <= quot_next;
        units_reg       <= units_next;
        tens_reg        <= tens_next;
        hund_reg        <= hund_next;
        m_tx_byte_reg   <= m_tx_byte_next;
        m_last_reg      <= m_last_next;
    end

    // ring valid marks and write pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_valid_reg <= '0;
            wptr_reg       <= '0;
        end else if (ring_write) begin
            ring_valid_reg[wptr_reg] <= 1'b1;
            wptr_reg <= (wptr_reg == RW'(RING_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ring_write) begin
            ring_value_reg[wptr_reg] <= s_sample;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_tx_byte = m_tx_byte_reg;
    assign m_last    = m_last_reg;

`ifndef SYNTHESIS
    a_out_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_EMIT || $past(state_reg) == ST_ERR))
        else $error("reply byte loaded outside an emit state");

    a_last_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> (m_tx_byte_reg == ASCII_COMMA ||
                                         m_tx_byte_reg == ASCII_O))
        else $error("last flag on a byte that cannot end a reply");

    a_div_valid_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> $past(rd_valid))
        else $error("conversion started on an unwritten ring slot");

    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && byte_cnt_reg != SLOT_HUND) |-> $past(!s_ready))
        else $error("input taken in the middle of a reply group");
`endif

endmodule

@@ tb/fcsr_reply_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsr_reply_checker
// Watches both channels of the sample reporter, keeps its own copy of the
// frame decoder and sample ring, and compares every reply byte with the text
// that the accepted commands should produce.
// ----------------------------------------------------------------------------
module fcsr_reply_checker
    import fcsr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_rx_byte,
    input  logic [7:0] s_sample,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_tx_byte,
    input  logic       m_last,
    output int         fail_count,
    output int         pending_bytes,
    output int         bytes_checked,
    output int         replies_checked
);

    localparam int SLOT_W = $clog2(RING_DEPTH_DEF);

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } reply_byte_t;

    reply_byte_t       reply_text [$];
    logic              in_frame;
    logic [POS_W-1:0]  frame_at;
    logic [7:0]        cmd_one;
    logic [7:0]        cmd_two;
    logic              slot_full [RING_DEPTH_DEF];
    logic [7:0]        slot_val  [RING_DEPTH_DEF];
    logic [SLOT_W-1:0] next_slot;
    int                errors;
    int                seen_bytes;
    int                seen_replies;

    initial begin
        fail_count      = 0;
        pending_bytes   = 0;
        bytes_checked   = 0;
        replies_checked = 0;
        errors          = 0;
        seen_bytes      = 0;
        seen_replies    = 0;
    end

    task automatic push_decimal(logic [7:0] v);
        reply_text.push_back('{ASCII_ZERO + v / 8'd100, 1'b0});
        reply_text.push_back('{ASCII_ZERO + (v / 8'd10) % 8'd10, 1'b0});
        reply_text.push_back('{ASCII_ZERO + v % 8'd10, 1'b0});
        reply_text.push_back('{ASCII_COMMA, 1'b0});
    endtask

    task automatic run_frame(logic [POS_W-1:0] end_pos);
        int                old_size;
        logic [SLOT_W-1:0] idx;
        reply_byte_t       tail;
        old_size = reply_text.size();
        if (end_pos >= 3 && cmd_one == BYTE_INSTR) begin
            if (cmd_two == BYTE_DUMP) begin
                if (end_pos == 3) begin
                    // oldest first: start at the slot about to be overwritten
                    for (int i = 0; i < RING_DEPTH_DEF; i++) begin
                        idx = SLOT_W'((int'(next_slot) + i) % RING_DEPTH_DEF);
                        if (slot_full[idx]) begin
                            push_decimal(slot_val[idx]);
                        end
                    end
                end
            end else if (cmd_two == BYTE_NEWEST) begin
                idx = SLOT_W'((int'(next_slot) + RING_DEPTH_DEF - 1) % RING_DEPTH_DEF);
                if (slot_full[idx]) begin
                    push_decimal(slot_val[idx]);
                end else begin
                    reply_text.push_back('{ASCII_E, 1'b0});
                    reply_text.push_back('{ASCII_R, 1'b0});
                    reply_text.push_back('{ASCII_R, 1'b0});
                    reply_text.push_back('{ASCII_O, 1'b0});
                end
            end
        end
        if (reply_text.size() > old_size) begin
            tail = reply_text.pop_back();
            tail.fin = 1'b1;
            reply_text.push_back(tail);
        end
    endtask

    task automatic take_item(logic req, logic [7:0] rx, logic [7:0] smp);
        logic [POS_W-1:0] end_pos;
        if (req) begin
            slot_val[next_slot]  = smp;
            slot_full[next_slot] = 1'b1;
            next_slot = SLOT_W'((int'(next_slot) + 1) % RING_DEPTH_DEF);
        end else if (!in_frame) begin
            if (rx == FRAME_OPEN) begin
                in_frame = 1'b1;
                frame_at = POS_W'(1);
            end
        end else if (rx == FRAME_CLOSE || frame_at >= POS_W'(FRAME_DEPTH - 1)) begin
            // a full buffer closes the frame whatever the byte is
            end_pos  = frame_at;
            in_frame = 1'b0;
            frame_at = '0;
            run_frame(end_pos);
        end else begin
            if (frame_at == 1) begin
                cmd_one = rx;
            end else if (frame_at == 2) begin
                cmd_two = rx;
            end
            frame_at = frame_at + 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        reply_byte_t want;
        if (!aresetn) begin
            in_frame  = 1'b0;
            frame_at  = '0;
            cmd_one   = 8'h00;
            cmd_two   = 8'h00;
            next_slot = '0;
            slot_full = '{default: 1'b0};
            slot_val  = '{default: 8'h00};
            reply_text.delete();
        end else begin
            // a reply byte can never belong to an item taken at the same edge
            if (m_valid && m_ready) begin
                if (reply_text.size() == 0) begin
                    errors++;
                    $display("%0t: reply byte with nothing expected: tx_byte 0x%02h last %0b",
                             $time, m_tx_byte, m_last);
                end else begin
                    want = reply_text.pop_front();
                    seen_bytes++;
                    if (want.fin) begin
                        seen_replies++;
                    end
                    if (m_tx_byte !== want.ch) begin
                        errors++;
                        $display("%0t: tx_byte mismatch: expected 0x%02h actual 0x%02h",
                                 $time, want.ch, m_tx_byte);
                    end
                    if (m_last !== want.fin) begin
                        errors++;
                        $display("%0t: last mismatch: expected %0b actual %0b",
                                 $time, want.fin, m_last);
                    end
                end
            end
            if (s_valid && s_ready) begin
                take_item(s_req_type, s_rx_byte, s_sample);
            end
        end
        fail_count      <= errors;
        pending_bytes   <= reply_text.size();
        bytes_checked   <= seen_bytes;
        replies_checked <= seen_replies;
    end

endmodule

@@ tb/framed_command_sample_reporter_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_command_sample_reporter_unit_test
// Drives sample stores, command frames and stray bytes into the reporter
// with random gaps and back-pressure; the reply checker predicts and
// compares every reply byte.
// ----------------------------------------------------------------------------
module framed_command_sample_reporter_unit_test;
    import fcsr_pkg::*;

    localparam logic REQ_BYTE     = 1'b0;
    localparam logic REQ_SAMPLE   = 1'b1;
    localparam int   RANDOM_ITEMS = 170;
    localparam int   HOLD_CYCLES  = 200;
    localparam int   TAIL_CYCLES  = 100;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic       s_req_type = 1'b0;
    logic [7:0] s_rx_byte  = 8'h00;
    logic [7:0] s_sample   = 8'h00;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    logic [7:0] m_tx_byte;
    logic       m_last;

    int fail_count;
    int pending_bytes;
    int bytes_checked;
    int replies_checked;

    int items_sent   = 0;
    int strays_sent  = 0;
    int dumps_sent   = 0;
    int newest_sent  = 0;
    int holds_asked  = 0;
    int holds_served = 0;
    bit tx_steady    = 1'b0;
    bit rx_steady    = 1'b0;

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    framed_command_sample_reporter_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_rx_byte  (s_rx_byte),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_tx_byte  (m_tx_byte),
        .m_last     (m_last)
    );

    fcsr_reply_checker reply_watch (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_rx_byte       (s_rx_byte),
        .s_sample        (s_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_tx_byte       (m_tx_byte),
        .m_last          (m_last),
        .fail_count      (fail_count),
        .pending_bytes   (pending_bytes),
        .bytes_checked   (bytes_checked),
        .replies_checked (replies_checked)
    );

    // receiver: random stalls, steady windows and long hold-offs on request
    initial begin
        forever begin
            @(posedge aclk);
            if (holds_served != holds_asked) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else if (rx_steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 29);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d reply bytes outstanding", pending_bytes);
        $display("framed_command_sample_reporter_unit verification failed");
        $finish;
    end

    task automatic send_item(logic req, logic [7:0] rx, logic [7:0] smp, bit stray);
        if (!tx_steady && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_rx_byte  <= rx;
        s_sample   <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (stray) begin
            strays_sent++;
        end else begin
            items_sent++;
        end
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(REQ_BYTE, b, 8'($urandom_range(255)), 1'b0);
    endtask

    task automatic send_sample(logic [7:0] v);
        send_item(REQ_SAMPLE, 8'($urandom_range(255)), v, 1'b0);
    endtask

    function automatic logic [7:0] filler_byte();
        logic [7:0] v;
        do begin
            v = 8'($urandom_range(255));
        end while (v == FRAME_CLOSE);
        return v;
    endfunction

    function automatic logic [7:0] sample_value();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // start, instruction, selector, optional padding, end
    task automatic send_command(logic [7:0] sel, int padding);
        send_byte(FRAME_OPEN);
        send_byte(BYTE_INSTR);
        send_byte(sel);
        repeat (padding) send_byte(filler_byte());
        send_byte(FRAME_CLOSE);
        if (sel == BYTE_DUMP) begin
            dumps_sent++;
        end else begin
            newest_sent++;
        end
    endtask

    task automatic wait_replies_done();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_bytes != 0) @(posedge aclk);
    endtask

    task automatic random_episode();
        int pick;
        int n;
        logic [7:0] v;
        pick = $urandom_range(99);
        if (pick < 30) begin
            send_sample(sample_value());
        end else if (pick < 52) begin
            // now and then one byte too many, which kills the dump
            send_command(BYTE_DUMP, ($urandom_range(99) < 15) ? 1 : 0);
        end else if (pick < 72) begin
            // long padding runs into the full frame buffer
            send_command(BYTE_NEWEST, $urandom_range(0, 5));
        end else if (pick < 85) begin
            send_byte(FRAME_OPEN);
            n = $urandom_range(0, 8);
            repeat (n) begin
                case ($urandom_range(5))
                    0:       send_byte(BYTE_INSTR);
                    1:       send_byte(BYTE_DUMP);
                    2:       send_byte(BYTE_NEWEST);
                    3:       send_byte(FRAME_OPEN);
                    4:       send_sample(sample_value());
                    default: send_byte(8'($urandom_range(255)));
                endcase
            end
            if ($urandom_range(1) == 1) begin
                send_byte(FRAME_CLOSE);
            end
        end else begin
            do begin
                v = 8'($urandom_range(255));
            end while (v == FRAME_OPEN);
            send_item(REQ_BYTE, v, 8'($urandom_range(255)), 1'b1);
        end
    endtask

    initial begin
        int base;
        int done;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: stray byte, newest on an empty ring, empty dump
        send_item(REQ_BYTE, 8'h55, 8'hAA, 1'b1);
        send_command(BYTE_NEWEST, 0);
        send_command(BYTE_DUMP, 0);
        send_sample(8'h00);
        send_sample(8'hFF);
        send_command(BYTE_DUMP, 0);
        // start byte inside a frame is plain data
        send_byte(FRAME_OPEN);
        send_byte(BYTE_INSTR);
        send_byte(BYTE_NEWEST);
        send_byte(FRAME_OPEN);
        send_byte(FRAME_CLOSE);
        newest_sent++;
        // too short to be a command
        send_byte(FRAME_OPEN);
        send_byte(FRAME_OPEN);
        send_byte(FRAME_CLOSE);
        wait_replies_done();

        // receiver holds off while a dump is built and the next item waits for s_ready
        repeat (3) send_sample(sample_value());
        holds_asked <= holds_asked + 1;
        send_command(BYTE_DUMP, 0);
        repeat (6) send_sample(sample_value());
        send_command(BYTE_NEWEST, 0);
        wait_replies_done();

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            done = items_sent - base;
            tx_steady = (done >= 100 && done < 150);
            rx_steady <= (done >= 100 && done < 150);
            random_episode();
        end
        tx_steady = 1'b0;
        rx_steady <= 1'b0;

        wait_replies_done();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run covered %0d items and %0d stray bytes, %0d dump and %0d newest commands",
                 items_sent, strays_sent, dumps_sent, newest_sent);
        $display("%0d reply bytes checked in %0d complete replies",
                 bytes_checked, replies_checked);
        if (fail_count == 0 && pending_bytes == 0) begin
            $display("framed_command_sample_reporter_unit verification clean");
        end else begin
            $display("framed_command_sample_reporter_unit verification failed");
        end
        $finish;
    end

endmodule
